// File: src/trs_pkg.sv
// transport_rx_session package: item, result and configuration types,
// session phases, control bytes and error codes
// no dependencies
package trs_pkg;

    localparam int BYTES_PER_PACKET = 7;

    // reciprocal of seven for the packet count: 74899 / 2^19, exact up to 65541
    localparam logic [16:0] RECIP_SEVEN = 17'd74899;
    localparam int          RECIP_SHIFT = 19;

    // item kinds on the input tuser
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_MGMT = 2'd1,
        FUNC_DATA = 2'd2,
        FUNC_NOP  = 2'd3
    } trs_func_t;

    // session phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_READ    = 2'd1,
        PH_ACKWAIT = 2'd2,
        PH_BAM     = 2'd3
    } trs_phase_t;

    // connection management control bytes
    localparam logic [7:0] CM_RTS     = 8'h10;
    localparam logic [7:0] CM_CTS     = 8'h11;
    localparam logic [7:0] CM_EOM_ACK = 8'h13;
    localparam logic [7:0] CM_ABORT   = 8'hFF;
    localparam logic [7:0] CM_BAM     = 8'h20;

    // error codes
    localparam logic [1:0] ERR_TIMEOUT  = 2'd0;
    localparam logic [1:0] ERR_MISMATCH = 2'd1;
    localparam logic [1:0] ERR_ABORT    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_ADDRESS  = 2'd0;
    localparam logic [1:0] REG_PEER_ADDRESS = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS   = 2'd2;
    localparam logic [1:0] REG_BUFFER_BYTES = 2'd3;

    typedef struct packed {
        logic [7:0]  own_address;
        logic [7:0]  peer_address;
        logic [15:0] timeout_ms;
        logic [15:0] buffer_bytes;
    } trs_cfg_t;

    typedef struct packed {
        trs_func_t   func;
        logic [7:0]  src_address;
        logic [7:0]  dst_address;
        logic [3:0]  frame_length;
        logic [63:0] frame_data;
    } trs_item_t;

    typedef struct packed {
        logic        send_cts;
        logic [7:0]  cts_packet_count;
        logic [7:0]  cts_next_seq;
        logic        write_valid;
        logic [10:0] write_offset;
        logic [2:0]  write_length;
        logic [55:0] write_data;
        logic        transfer_done;
        logic        transfer_error;
        logic [1:0]  error_code;
        logic [23:0] message_pgn;
        logic [15:0] message_size;
    } trs_result_t;

endpackage

// File: src/trs_session.sv
// transport_rx_session session engine: phase and session state, one item
// processed per step in a single combinational pass
// depends on trs_pkg
module trs_session
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  trs_pkg::trs_item_t   item,
    input  trs_pkg::trs_cfg_t    cfg,
    output trs_pkg::trs_result_t result
);

    trs_pkg::trs_phase_t phase_reg, phase_next;
    logic [23:0] pgn_reg, pgn_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] expected_reg, expected_next;
    logic [15:0] idle_reg, idle_next;

    logic        match;
    logic [7:0]  ctl;
    logic [16:0] size_round;
    logic [33:0] recip_prod;
    logic [15:0] rts_size;
    logic [15:0] rts_packets;
    logic [23:0] rts_pgn;
    logic [15:0] idle_inc;
    logic [15:0] ack_size;
    logic [7:0]  ack_packets;
    logic [7:0]  seq_less;
    logic [10:0] offset;
    logic [16:0] remain;
    logic [3:0]  avail;
    logic [2:0]  wr_len;
    logic [16:0] wr_end;
    logic [15:0] left_dec;
    logic [55:0] wr_mask;

    // announced session values from a request or broadcast announce
    always_comb
    begin
        rts_size    = {item.frame_data[23:16], item.frame_data[15:8]};
        rts_pgn     = item.frame_data[63:40];
        size_round  = {1'b0, rts_size} + 17'(trs_pkg::BYTES_PER_PACKET - 1);
        recip_prod  = 34'(size_round) * 34'(trs_pkg::RECIP_SEVEN);
        rts_packets = 16'(recip_prod[33:trs_pkg::RECIP_SHIFT]);
    end

    // data packet placement, clipped to the session size
    always_comb
    begin
        seq_less = item.frame_data[7:0] - 8'd1;
        offset   = ({3'b000, seq_less} << 3) - {3'b000, seq_less};
        remain   = {1'b0, size_reg} - {6'b000000, offset};
        if (item.frame_length == 4'd0)
            avail = 4'd0;
        else if (item.frame_length > 4'd8)
            avail = 4'd7;
        else
            avail = item.frame_length - 4'd1;
        if (remain > 17'(avail))
            wr_len = avail[2:0];
        else
            wr_len = remain[2:0];
        wr_end = {6'b000000, offset} + {14'd0, wr_len};
        for (int i = 0; i < 7; i++)
            wr_mask[i*8 +: 8] = (3'(i) < wr_len) ? 8'hFF : 8'h00;
        left_dec = (left_reg != 16'd0) ? left_reg - 16'd1 : 16'd0;
    end

    // next state and result for one item
    always_comb
    begin
        match       = (item.src_address == cfg.peer_address) &&
                      (item.dst_address == cfg.own_address);
        ctl         = item.frame_data[7:0];
        idle_inc    = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
        ack_size    = {item.frame_data[23:16], item.frame_data[15:8]};
        ack_packets = item.frame_data[31:24];

        phase_next    = phase_reg;
        pgn_next      = pgn_reg;
        size_next     = size_reg;
        left_next     = left_reg;
        expected_next = expected_reg;
        idle_next     = idle_reg;
        result        = '0;

        case (item.func)
            trs_pkg::FUNC_TICK:
            begin
                if (phase_reg == trs_pkg::PH_READ || phase_reg == trs_pkg::PH_ACKWAIT)
                begin
                    idle_next = idle_inc;
                    if (idle_inc > cfg.timeout_ms)
                    begin
                        result.transfer_error = 1'b1;
                        result.error_code     = trs_pkg::ERR_TIMEOUT;
                        phase_next            = trs_pkg::PH_IDLE;
                    end
                end
            end
            trs_pkg::FUNC_MGMT:
            begin
                if (match)
                begin
                    case (ctl)
                        trs_pkg::CM_RTS, trs_pkg::CM_BAM:
                        begin
                            if (phase_reg == trs_pkg::PH_IDLE)
                            begin
                                pgn_next      = rts_pgn;
                                size_next     = rts_size;
                                left_next     = rts_packets;
                                expected_next = rts_packets;
                                idle_next     = 16'd0;
                                if (ctl == trs_pkg::CM_RTS)
                                begin
                                    phase_next              = trs_pkg::PH_READ;
                                    result.send_cts         = 1'b1;
                                    result.cts_packet_count = rts_packets[7:0];
                                end
                                else
                                    phase_next = trs_pkg::PH_BAM;
                            end
                        end
                        trs_pkg::CM_EOM_ACK:
                        begin
                            if (phase_reg == trs_pkg::PH_ACKWAIT)
                            begin
                                if (idle_reg > cfg.timeout_ms)
                                begin
                                    result.transfer_error = 1'b1;
                                    result.error_code     = trs_pkg::ERR_TIMEOUT;
                                end
                                else if (ack_size != size_reg ||
                                         ack_packets != expected_reg[7:0])
                                begin
                                    result.transfer_error = 1'b1;
                                    result.error_code     = trs_pkg::ERR_MISMATCH;
                                end
                                idle_next  = 16'd0;
                                phase_next = trs_pkg::PH_IDLE;
                            end
                        end
                        trs_pkg::CM_ABORT:
                        begin
                            if (phase_reg != trs_pkg::PH_IDLE)
                            begin
                                result.transfer_error = 1'b1;
                                result.error_code     = trs_pkg::ERR_ABORT;
                                phase_next            = trs_pkg::PH_IDLE;
                            end
                        end
                        default:
                        begin
                            // clear-to-send and unknown control bytes are ignored
                        end
                    endcase
                end
            end
            trs_pkg::FUNC_DATA:
            begin
                if (match && (phase_reg == trs_pkg::PH_READ || phase_reg == trs_pkg::PH_BAM))
                begin
                    idle_next = 16'd0;
                    left_next = left_dec;
                    if (ctl != 8'd0 && remain[16] == 1'b0 && remain != 17'd0 &&
                        wr_len != 3'd0 && wr_end < {1'b0, cfg.buffer_bytes})
                    begin
                        result.write_valid  = 1'b1;
                        result.write_offset = offset;
                        result.write_length = wr_len;
                        result.write_data   = item.frame_data[63:8] & wr_mask;
                    end
                    if (left_dec == 16'd0)
                    begin
                        result.transfer_done = 1'b1;
                        phase_next = (phase_reg == trs_pkg::PH_READ) ?
                                     trs_pkg::PH_ACKWAIT : trs_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                // no operation
            end
        endcase

        result.message_pgn  = pgn_next;
        result.message_size = size_next;
    end

    // session state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= trs_pkg::PH_IDLE;
            pgn_reg      <= '0;
            size_reg     <= '0;
            left_reg     <= '0;
            expected_reg <= '0;
            idle_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pgn_reg      <= pgn_next;
            size_reg     <= size_next;
            left_reg     <= left_next;
            expected_reg <= expected_next;
            idle_reg     <= idle_next;
        end
    end

`ifndef SYNTHESIS
    // a completed transfer always leaves the data phases
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.transfer_done |=>
            (phase_reg == trs_pkg::PH_ACKWAIT || phase_reg == trs_pkg::PH_IDLE))
        else $error("transfer done without leaving the data phase");

    // any error returns the session to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.transfer_error |=> phase_reg == trs_pkg::PH_IDLE)
        else $error("error reported but session not idle");

    // a clear-to-send only answers a request taken while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.send_cts |=>
            phase_reg == trs_pkg::PH_READ && $past(phase_reg) == trs_pkg::PH_IDLE)
        else $error("clear-to-send outside session start");
`endif

endmodule

// File: src/transport_rx_session.sv
// transport_rx_session: receive side of one multi-frame transport session
// Channels: the slave stream carries ticks, management frames and data frames
// (kind in s_tuser); the master stream carries one result per item: a
// clear-to-send request, a byte write, completion and error flags, and the
// session group number and size after the item.
// A separate write channel sets own address, peer address, timeout in ticks
// and buffer capacity; it is always ready. Use it only while the block is
// idle; the block does not enforce this. An item passes the input register,
// then the result register. Throughput: one item per cycle while m_tready is
// high; the item's session update is one combinational pass between the two.
// Reset: session idle with cleared state, registers at their reset values
// (timeout 1250, buffer 1785 bytes), no result pending.
// Stall: when m_tready is low the result register holds its transfer, the
// input register takes one more item and then s_tready drops until the
// result is taken; nothing is dropped or repeated.
// depends on trs_pkg and trs_session
module transport_rx_session
(
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: src_address, dst_address, frame_length, frame_data, zero pad
    input  logic [87:0]  s_tdata,
    // tuser: func
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: send_cts, cts_packet_count, cts_next_seq, write_valid,
    // write_offset, write_length, write_data, transfer_done, transfer_error,
    // error_code, message_pgn, message_size, zero pad
    output logic [135:0] m_tdata,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    trs_pkg::trs_cfg_t    cfg_reg;
    trs_pkg::trs_item_t   item_reg;
    trs_pkg::trs_result_t result;
    trs_pkg::trs_result_t out_reg;
    logic                 in_valid_reg;
    logic                 out_valid_reg;
    logic                 advance;
    logic                 in_take;

    // handshake between the input register and the result register
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address  <= 8'd0;
            cfg_reg.peer_address <= 8'd0;
            cfg_reg.timeout_ms   <= 16'd1250;
            cfg_reg.buffer_bytes <= 16'd1785;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                trs_pkg::REG_OWN_ADDRESS:  cfg_reg.own_address  <= cfg_data[7:0];
                trs_pkg::REG_PEER_ADDRESS: cfg_reg.peer_address <= cfg_data[7:0];
                trs_pkg::REG_TIMEOUT_MS:   cfg_reg.timeout_ms   <= cfg_data;
                trs_pkg::REG_BUFFER_BYTES: cfg_reg.buffer_bytes <= cfg_data;
                default:                   cfg_reg.own_address  <= cfg_reg.own_address;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.func         <= trs_pkg::trs_func_t'(s_tuser);
            item_reg.src_address  <= s_tdata[7:0];
            item_reg.dst_address  <= s_tdata[15:8];
            item_reg.frame_length <= s_tdata[19:16];
            item_reg.frame_data   <= s_tdata[83:20];
        end
    end

    trs_session u_session
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_tready)
            out_valid_reg <= advance;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    // result packing, first field in the lowest bits
    assign m_tdata = {4'd0,
                      out_reg.message_size,
                      out_reg.message_pgn,
                      out_reg.error_code,
                      out_reg.transfer_error,
                      out_reg.transfer_done,
                      out_reg.write_data,
                      out_reg.write_length,
                      out_reg.write_offset,
                      out_reg.write_valid,
                      out_reg.cts_next_seq,
                      out_reg.cts_packet_count,
                      out_reg.send_cts};

`ifndef SYNTHESIS
    // a held item is never lost while the result side is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending item dropped");

    // every processed item produces a result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item has no result");

    // a result carries at most one of clear-to-send, write and error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({out_reg.send_cts, out_reg.write_valid,
                                    out_reg.transfer_error}))
        else $error("conflicting result flags");

    // the clear-to-send next packet field stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.cts_next_seq == 8'd0)
        else $error("clear-to-send next packet not zero");
`endif

endmodule
